// File: rtl/glct_pkg.sv
// Shared types, codes and constants of the gate line crossing table.
package glct_pkg;

  localparam int GATE_COUNT_DEF = 8;
  localparam int DIV_STEPS = 16;
  localparam int MOD_Q_LSB = 40;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_GET   = 2'd2;
  localparam logic [1:0] KIND_CHECK = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [18:0]        TWO_PI_Q  = 19'd411775;
  localparam logic signed [20:0] TWO_PI_S  = 21'sd411775;
  localparam logic signed [20:0] PI_Q      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q = 21'sd102944;
  localparam logic signed [33:0] RECIP_M   = 34'sd2670175;

  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [33:0] SIN_C0  = -34'sd178956971;
  localparam logic signed [33:0] SIN_C1  = 34'sd8947849;
  localparam logic signed [33:0] SIN_C2  = -34'sd213044;
  localparam logic signed [33:0] SIN_C3  = 34'sd2959;
  localparam logic signed [33:0] SIN_C4  = -34'sd27;
  localparam logic signed [33:0] COS_C0  = -34'sd536870912;
  localparam logic signed [33:0] COS_C1  = 34'sd44739243;
  localparam logic signed [33:0] COS_C2  = -34'sd1491308;
  localparam logic signed [33:0] COS_C3  = 34'sd26631;
  localparam logic signed [33:0] COS_C4  = -34'sd296;

  localparam logic [4:0] SH_NONE = 5'd0;
  localparam logic [4:0] SH_RND  = 5'd14;
  localparam logic [4:0] SH_Q16  = 5'd16;
  localparam logic [4:0] SH_Q30  = 5'd30;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         gate_index;
    logic signed [31:0] first_east;
    logic signed [31:0] first_north;
    logic signed [31:0] second_east;
    logic signed [31:0] second_north;
    logic signed [31:0] heading;
  } glct_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               crossed;
    logic [16:0]        fraction;
    logic signed [31:0] gate_east_out;
    logic signed [31:0] gate_north_out;
    logic signed [31:0] gate_heading_out;
  } glct_out_t;

  typedef struct packed {
    logic signed [33:0] a;
    logic signed [33:0] b;
    logic [4:0]         sh;
  } glct_mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_FOLD, S_OP, S_TEST, S_DIV, S_FIN, S_DONE
  } glct_state_t;

  typedef enum logic [4:0] {
    OP_X2, OP_SIN3, OP_SIN2, OP_SIN1, OP_SIN0, OP_COS3, OP_COS2, OP_COS1, OP_COS0,
    OP_SIN_ONE, OP_COS_ONE, OP_SIN_X, OP_SIN_RND, OP_COS_RND,
    OP_SP_A, OP_SP_B, OP_SC_A, OP_SC_B, OP_XE, OP_XN, OP_OFF_A, OP_OFF_B,
    OP_MOD_Q, OP_MOD_P
  } glct_op_t;

endpackage

// File: rtl/glct_ram.sv
// Generic single-port RAM with registered read.
module glct_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/glct_mul.sv
// Shared two-stage signed multiplier with rounding right shift.
module glct_mul (
  input  logic                   clk,
  input  glct_pkg::glct_mul_req_t req,
  output logic signed [63:0]     res
);

  logic [33:0]        amag;
  logic [33:0]        bmag;
  logic [65:0]        full;
  logic [63:0]        p_r;
  logic               neg_r;
  logic [4:0]         sh_r;
  logic [63:0]        rnd;
  logic [63:0]        mag;
  logic signed [63:0] res_r;

  always_comb begin
    amag = req.a[33] ? 34'(-req.a) : 34'(req.a);
    bmag = req.b[33] ? 34'(-req.b) : 34'(req.b);
    full = amag[32:0] * bmag[32:0];
    rnd  = (sh_r == glct_pkg::SH_NONE) ? 64'd0 : (64'd1 << (sh_r - 5'd1));
    mag  = (p_r + rnd) >> sh_r;
  end

  always_ff @(posedge clk) begin
    p_r   <= full[63:0];
    neg_r <= req.a[33] ^ req.b[33];
    sh_r  <= req.sh;
    res_r <= neg_r ? -$signed(mag) : $signed(mag);
  end

  assign res = res_r;

endmodule

// File: rtl/gate_line_crossing_table_unit.sv
// Gate line crossing table: top level with sequencer and datapath.
//
// Input channel in_valid/in_ready/in_data carries one command (set, clear,
// get or check of a gate). Each accepted command gives exactly one result on
// out_valid/out_ready/out_data. cfg_we/cfg_wdata write the half width.
// Set, clear, out-of-range and invalid-gate commands go from the accepting
// state straight to S_DONE, which loads the result register; a get first
// reads the gate in S_READ. A check reads it, then 2 multiply steps reduce
// the heading, 14 give sine and cosine, 4 the projections, then a 16-step
// fraction division and 4 more multiply steps, all through the one shared
// two-stage multiplier. A check that fails the sign test ends at S_TEST.
// in_ready is high only while the sequencer is idle, so one command is in
// work at a time; a next command can be taken in the cycle after a result is
// loaded. A finished result sits in the output register; a new command is
// taken while it waits, and its own result is held until the receiver takes
// the earlier one. Reset clears all gate valid bits, sets half width to 2560
// and empties the output register.
module gate_line_crossing_table_unit #(
  parameter int GATE_COUNT = glct_pkg::GATE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  glct_pkg::glct_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output glct_pkg::glct_out_t out_data,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_wdata
);

  localparam int IDX_W = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;

  glct_pkg::glct_state_t state_r, state_nxt;
  glct_pkg::glct_op_t    op_r, op_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic [4:0]            bit_cnt_r, bit_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  glct_pkg::glct_out_t   out_data_r, out_data_nxt;
  logic [23:0]           hw_r, hw_nxt;
  logic [GATE_COUNT-1:0] valid_r, valid_nxt;

  glct_pkg::glct_in_t    item_r, item_nxt;
  glct_pkg::glct_out_t   res_r, res_nxt;
  logic [31:0]           dvd_r, dvd_nxt;
  logic                  hneg_r, hneg_nxt;
  logic [12:0]           mq_r, mq_nxt;
  logic [18:0]           mrem_r, mrem_nxt;
  logic                  sneg_r, sneg_nxt;
  logic                  cneg_r, cneg_nxt;
  logic signed [33:0]    x_r, x_nxt;
  logic signed [33:0]    x2_r, x2_nxt;
  logic signed [33:0]    s_r, s_nxt;
  logic signed [33:0]    c_r, c_nxt;
  logic signed [63:0]    acc_r, acc_nxt;
  logic signed [52:0]    sp_r, sp_nxt;
  logic signed [52:0]    sc_r, sc_nxt;
  logic signed [32:0]    dpe_r, dpe_nxt;
  logic signed [32:0]    dpn_r, dpn_nxt;
  logic signed [32:0]    dce_r, dce_nxt;
  logic signed [32:0]    dcn_r, dcn_nxt;
  logic signed [32:0]    de_r, de_nxt;
  logic signed [32:0]    dn_r, dn_nxt;
  logic signed [33:0]    xe_r, xe_nxt;
  logic signed [33:0]    xn_r, xn_nxt;
  logic [52:0]           drem_r, drem_nxt;
  logic [52:0]           den_r, den_nxt;
  logic [16:0]           q_r, q_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [95:0]           ram_wdata;
  logic [95:0]           ram_rdata;
  glct_pkg::glct_mul_req_t mreq;
  logic signed [63:0]    mres;
  logic signed [33:0]    mres34;

  logic [IDX_W-1:0]      in_addr;
  logic [32:0]           mod_d;
  logic signed [20:0]    r0;
  logic signed [20:0]    r1;
  logic signed [20:0]    fa;
  logic signed [53:0]    fwd;
  logic [52:0]           div_t;
  logic [63:0]           off_mag;
  logic signed [31:0]    rd_e;
  logic signed [31:0]    rd_n;
  logic signed [31:0]    rd_h;

  glct_ram #(.WIDTH(96), .DEPTH(GATE_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  glct_mul u_mul (
    .clk (clk),
    .req (mreq),
    .res (mres)
  );

  assign in_ready  = (state_r == glct_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_addr   = in_data.gate_index[IDX_W-1:0];
  assign ram_addr  = in_addr;
  assign ram_wdata = {in_data.first_east, in_data.first_north, in_data.heading};
  assign mres34    = mres[33:0];
  assign rd_e      = ram_rdata[95:64];
  assign rd_n      = ram_rdata[63:32];
  assign rd_h      = ram_rdata[31:0];

  always_comb begin
    mreq = '0;
    case (op_r)
      glct_pkg::OP_MOD_Q: begin
        mreq = '{a: {2'b00, dvd_r}, b: glct_pkg::RECIP_M, sh: glct_pkg::SH_NONE};
      end
      glct_pkg::OP_MOD_P: begin
        mreq = '{a: {21'd0, mq_r}, b: {15'd0, glct_pkg::TWO_PI_Q}, sh: glct_pkg::SH_NONE};
      end
      glct_pkg::OP_X2: begin
        mreq = '{a: x_r, b: x_r, sh: glct_pkg::SH_Q30};
      end
      glct_pkg::OP_SIN3, glct_pkg::OP_SIN2, glct_pkg::OP_SIN1, glct_pkg::OP_SIN0,
      glct_pkg::OP_SIN_ONE: begin
        mreq = '{a: x2_r, b: s_r, sh: glct_pkg::SH_Q30};
      end
      glct_pkg::OP_COS3, glct_pkg::OP_COS2, glct_pkg::OP_COS1, glct_pkg::OP_COS0,
      glct_pkg::OP_COS_ONE: begin
        mreq = '{a: x2_r, b: c_r, sh: glct_pkg::SH_Q30};
      end
      glct_pkg::OP_SIN_X: begin
        mreq = '{a: x_r, b: s_r, sh: glct_pkg::SH_Q30};
      end
      glct_pkg::OP_SIN_RND: begin
        mreq = '{a: s_r, b: 34'sd1, sh: glct_pkg::SH_RND};
      end
      glct_pkg::OP_COS_RND: begin
        mreq = '{a: c_r, b: 34'sd1, sh: glct_pkg::SH_RND};
      end
      glct_pkg::OP_SP_A: begin
        mreq = '{a: {dpe_r[32], dpe_r}, b: c_r, sh: glct_pkg::SH_NONE};
      end
      glct_pkg::OP_SP_B: begin
        mreq = '{a: {dpn_r[32], dpn_r}, b: s_r, sh: glct_pkg::SH_NONE};
      end
      glct_pkg::OP_SC_A: begin
        mreq = '{a: {dce_r[32], dce_r}, b: c_r, sh: glct_pkg::SH_NONE};
      end
      glct_pkg::OP_SC_B: begin
        mreq = '{a: {dcn_r[32], dcn_r}, b: s_r, sh: glct_pkg::SH_NONE};
      end
      glct_pkg::OP_XE: begin
        mreq = '{a: {17'd0, q_r}, b: {de_r[32], de_r}, sh: glct_pkg::SH_Q16};
      end
      glct_pkg::OP_XN: begin
        mreq = '{a: {17'd0, q_r}, b: {dn_r[32], dn_r}, sh: glct_pkg::SH_Q16};
      end
      glct_pkg::OP_OFF_A: begin
        mreq = '{a: -xe_r, b: s_r, sh: glct_pkg::SH_NONE};
      end
      glct_pkg::OP_OFF_B: begin
        mreq = '{a: xn_r, b: c_r, sh: glct_pkg::SH_NONE};
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    hw_nxt        = hw_r;
    valid_nxt     = valid_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    dvd_nxt       = dvd_r;
    hneg_nxt      = hneg_r;
    mq_nxt        = mq_r;
    mrem_nxt      = mrem_r;
    sneg_nxt      = sneg_r;
    cneg_nxt      = cneg_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    s_nxt         = s_r;
    c_nxt         = c_r;
    acc_nxt       = acc_r;
    sp_nxt        = sp_r;
    sc_nxt        = sc_r;
    dpe_nxt       = dpe_r;
    dpn_nxt       = dpn_r;
    dce_nxt       = dce_r;
    dcn_nxt       = dcn_r;
    de_nxt        = de_r;
    dn_nxt        = dn_r;
    xe_nxt        = xe_r;
    xn_nxt        = xn_r;
    drem_nxt      = drem_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    ram_we        = 1'b0;
    mod_d         = {1'b0, dvd_r} - mres[32:0];
    r0            = '0;
    r1            = '0;
    fa            = '0;
    fwd           = 54'(sc_r) - 54'(sp_r);
    div_t         = {drem_r[51:0], 1'b0};
    off_mag       = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);

    if (cfg_we) begin
      hw_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      glct_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          res_nxt   = '0;
          state_nxt = glct_pkg::S_DONE;
          if ({1'b0, in_data.gate_index} >= 9'(GATE_COUNT)) begin
            res_nxt.status = glct_pkg::ST_RANGE;
          end else begin
            case (in_data.kind)
              glct_pkg::KIND_SET: begin
                ram_we = 1'b1;
                if (in_addr == '0) begin
                  valid_nxt = '0;
                end
                valid_nxt[in_addr] = 1'b1;
              end
              glct_pkg::KIND_CLEAR: begin
                valid_nxt[in_addr] = 1'b0;
              end
              default: begin
                if (!valid_r[in_addr]) begin
                  res_nxt.status = glct_pkg::ST_INVALID;
                end else begin
                  state_nxt = glct_pkg::S_READ;
                end
              end
            endcase
          end
        end
      end
      glct_pkg::S_READ: begin
        if (item_r.kind == glct_pkg::KIND_GET) begin
          res_nxt.gate_east_out    = rd_e;
          res_nxt.gate_north_out   = rd_n;
          res_nxt.gate_heading_out = rd_h;
          state_nxt                = glct_pkg::S_DONE;
        end else begin
          dpe_nxt     = {item_r.first_east[31], item_r.first_east} - {rd_e[31], rd_e};
          dpn_nxt     = {item_r.first_north[31], item_r.first_north} - {rd_n[31], rd_n};
          dce_nxt     = {item_r.second_east[31], item_r.second_east} - {rd_e[31], rd_e};
          dcn_nxt     = {item_r.second_north[31], item_r.second_north} - {rd_n[31], rd_n};
          de_nxt      = {item_r.second_east[31], item_r.second_east}
                      - {item_r.first_east[31], item_r.first_east};
          dn_nxt      = {item_r.second_north[31], item_r.second_north}
                      - {item_r.first_north[31], item_r.first_north};
          hneg_nxt    = rd_h[31];
          dvd_nxt     = rd_h[31] ? 32'(-rd_h) : 32'(rd_h);
          op_nxt      = glct_pkg::OP_MOD_Q;
          cnt_nxt     = '0;
          state_nxt   = glct_pkg::S_OP;
        end
      end
      glct_pkg::S_FOLD: begin
        r0 = hneg_r ? -$signed({2'b00, mrem_r}) : $signed({2'b00, mrem_r});
        r1 = r0;
        if (r0 > glct_pkg::PI_Q) begin
          r1 = r0 - glct_pkg::TWO_PI_S;
        end else if (r0 <= -glct_pkg::PI_Q) begin
          r1 = r0 + glct_pkg::TWO_PI_S;
        end
        sneg_nxt = r1[20];
        fa       = r1[20] ? -r1 : r1;
        cneg_nxt = 1'b0;
        if (fa > glct_pkg::HALF_PI_Q) begin
          fa       = glct_pkg::PI_Q - fa;
          cneg_nxt = 1'b1;
        end
        if (fa[20]) begin
          fa = '0;
        end
        x_nxt     = {fa[19:0], 14'd0};
        s_nxt     = glct_pkg::SIN_C4;
        c_nxt     = glct_pkg::COS_C4;
        op_nxt    = glct_pkg::OP_X2;
        cnt_nxt   = '0;
        state_nxt = glct_pkg::S_OP;
      end
      glct_pkg::S_OP: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          cnt_nxt = '0;
          op_nxt  = glct_pkg::glct_op_t'(op_r + 5'd1);
          case (op_r)
            glct_pkg::OP_MOD_Q:   mq_nxt = mres[glct_pkg::MOD_Q_LSB +: 13];
            glct_pkg::OP_MOD_P: begin
              if (mod_d >= {14'd0, glct_pkg::TWO_PI_Q}) begin
                mrem_nxt = 19'(mod_d - {14'd0, glct_pkg::TWO_PI_Q});
              end else begin
                mrem_nxt = mod_d[18:0];
              end
              op_nxt    = glct_pkg::OP_X2;
              state_nxt = glct_pkg::S_FOLD;
            end
            glct_pkg::OP_X2:      x2_nxt = mres34;
            glct_pkg::OP_SIN3:    s_nxt = glct_pkg::SIN_C3 + mres34;
            glct_pkg::OP_SIN2:    s_nxt = glct_pkg::SIN_C2 + mres34;
            glct_pkg::OP_SIN1:    s_nxt = glct_pkg::SIN_C1 + mres34;
            glct_pkg::OP_SIN0:    s_nxt = glct_pkg::SIN_C0 + mres34;
            glct_pkg::OP_COS3:    c_nxt = glct_pkg::COS_C3 + mres34;
            glct_pkg::OP_COS2:    c_nxt = glct_pkg::COS_C2 + mres34;
            glct_pkg::OP_COS1:    c_nxt = glct_pkg::COS_C1 + mres34;
            glct_pkg::OP_COS0:    c_nxt = glct_pkg::COS_C0 + mres34;
            glct_pkg::OP_SIN_ONE: s_nxt = glct_pkg::ONE_Q30 + mres34;
            glct_pkg::OP_COS_ONE: c_nxt = glct_pkg::ONE_Q30 + mres34;
            glct_pkg::OP_SIN_X:   s_nxt = mres34;
            glct_pkg::OP_SIN_RND: s_nxt = sneg_r ? -mres34 : mres34;
            glct_pkg::OP_COS_RND: c_nxt = cneg_r ? -mres34 : mres34;
            glct_pkg::OP_SP_A:    acc_nxt = mres;
            glct_pkg::OP_SP_B:    sp_nxt = 53'(acc_r + mres);
            glct_pkg::OP_SC_A:    acc_nxt = mres;
            glct_pkg::OP_SC_B: begin
              sc_nxt    = 53'(acc_r + mres);
              state_nxt = glct_pkg::S_TEST;
            end
            glct_pkg::OP_XE:      xe_nxt = {dpe_r[32], dpe_r} + mres34;
            glct_pkg::OP_XN:      xn_nxt = {dpn_r[32], dpn_r} + mres34;
            glct_pkg::OP_OFF_A:   acc_nxt = mres;
            glct_pkg::OP_OFF_B: begin
              acc_nxt   = acc_r + mres;
              state_nxt = glct_pkg::S_FIN;
            end
            default: begin
              state_nxt = glct_pkg::S_DONE;
            end
          endcase
        end
      end
      glct_pkg::S_TEST: begin
        if (sp_r <= 0 && sc_r > 0 && fwd > 0) begin
          drem_nxt    = 53'(-sp_r);
          den_nxt     = 53'(fwd);
          q_nxt       = '0;
          bit_cnt_nxt = '0;
          state_nxt   = glct_pkg::S_DIV;
        end else begin
          state_nxt = glct_pkg::S_DONE;
        end
      end
      glct_pkg::S_DIV: begin
        if (div_t >= den_r) begin
          drem_nxt = div_t - den_r;
          q_nxt    = {q_r[15:0], 1'b1};
        end else begin
          drem_nxt = div_t;
          q_nxt    = {q_r[15:0], 1'b0};
        end
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'(glct_pkg::DIV_STEPS - 1)) begin
          if (q_nxt > 17'd65536) begin
            q_nxt = 17'd65536;
          end
          op_nxt    = glct_pkg::OP_XE;
          cnt_nxt   = '0;
          state_nxt = glct_pkg::S_OP;
        end
      end
      glct_pkg::S_FIN: begin
        if (off_mag <= {24'd0, hw_r, 16'd0}) begin
          res_nxt.crossed  = 1'b1;
          res_nxt.fraction = q_r;
        end
        state_nxt = glct_pkg::S_DONE;
      end
      glct_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = glct_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = glct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glct_pkg::S_IDLE;
      op_r        <= glct_pkg::OP_X2;
      cnt_r       <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      hw_r        <= 24'd2560;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hw_r        <= hw_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    dvd_r      <= dvd_nxt;
    hneg_r     <= hneg_nxt;
    mq_r       <= mq_nxt;
    mrem_r     <= mrem_nxt;
    sneg_r     <= sneg_nxt;
    cneg_r     <= cneg_nxt;
    x_r        <= x_nxt;
    x2_r       <= x2_nxt;
    s_r        <= s_nxt;
    c_r        <= c_nxt;
    acc_r      <= acc_nxt;
    sp_r       <= sp_nxt;
    sc_r       <= sc_nxt;
    dpe_r      <= dpe_nxt;
    dpn_r      <= dpn_nxt;
    dce_r      <= dce_nxt;
    dcn_r      <= dcn_nxt;
    de_r       <= de_nxt;
    dn_r       <= dn_nxt;
    xe_r       <= xe_nxt;
    xn_r       <= xn_nxt;
    drem_r     <= drem_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
  end

  a_range_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ({1'b0, in_data.gate_index} >= 9'(GATE_COUNT)))
    |=> (state_r == glct_pkg::S_DONE && res_r.status == glct_pkg::ST_RANGE))
    else $error("out-of-range index did not report range status");

  a_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind == glct_pkg::KIND_SET &&
     in_data.gate_index == 8'd0) |=> (valid_r == GATE_COUNT'(1)))
    else $error("set of gate zero left other gates valid");

  a_crossed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.crossed) |-> (out_data.status == glct_pkg::ST_OK))
    else $error("crossing reported with nonzero status");

  a_fraction_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.crossed) |-> (out_data.fraction == 17'd0))
    else $error("fraction set without crossing");

  a_fraction_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fraction <= 17'd65536))
    else $error("fraction above one");

endmodule

// File: bench/tb_gate_line_crossing_table_unit.sv
// Self-checking testbench for the gate line crossing table: table commands and crossing checks.
`timescale 1ns / 100ps

module tb_gate_line_crossing_table_unit;

  localparam int GATES = 8;

  class crossing_scoreboard;
    longint gate_east[GATES];
    longint gate_north[GATES];
    longint gate_heading[GATES];
    bit gate_valid[GATES];
    longint unsigned half_width;
    glct_pkg::glct_out_t expected_results[$];
    int errors;

    function new();
      foreach (gate_valid[i]) begin
        gate_valid[i] = 0;
        gate_east[i] = 0;
        gate_north[i] = 0;
        gate_heading[i] = 0;
      end
      half_width = 2560;
      errors = 0;
    endfunction

    function longint round_mul(longint a, longint b, int sh);
      longint unsigned ma, mb, m;
      ma = (a < 0) ? longint'(-a) : a;
      mb = (b < 0) ? longint'(-b) : b;
      m = (ma * mb + (64'd1 << (sh - 1))) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function void sin_cos(longint h, output longint sn, output longint cs);
      longint r, a, x, x2, s, c;
      longint sc[5], cc[5];
      bit sneg, cneg;
      sc = '{longint'(glct_pkg::SIN_C0), longint'(glct_pkg::SIN_C1),
             longint'(glct_pkg::SIN_C2), longint'(glct_pkg::SIN_C3),
             longint'(glct_pkg::SIN_C4)};
      cc = '{longint'(glct_pkg::COS_C0), longint'(glct_pkg::COS_C1),
             longint'(glct_pkg::COS_C2), longint'(glct_pkg::COS_C3),
             longint'(glct_pkg::COS_C4)};
      r = h - (h / longint'(glct_pkg::TWO_PI_S)) * longint'(glct_pkg::TWO_PI_S);
      if (r > longint'(glct_pkg::PI_Q)) r -= longint'(glct_pkg::TWO_PI_S);
      else if (r <= -longint'(glct_pkg::PI_Q)) r += longint'(glct_pkg::TWO_PI_S);
      sneg = r < 0;
      cneg = 0;
      a = sneg ? -r : r;
      if (a > longint'(glct_pkg::HALF_PI_Q)) begin
        a = longint'(glct_pkg::PI_Q) - a;
        cneg = 1;
      end
      if (a < 0) a = 0;
      x = a * 16384;
      x2 = round_mul(x, x, 30);
      s = sc[4];
      c = cc[4];
      for (int i = 3; i >= 0; i--) begin
        s = sc[i] + round_mul(x2, s, 30);
        c = cc[i] + round_mul(x2, c, 30);
      end
      s = longint'(glct_pkg::ONE_Q30) + round_mul(x2, s, 30);
      s = round_mul(x, s, 30);
      c = longint'(glct_pkg::ONE_Q30) + round_mul(x2, c, 30);
      s = round_mul(s, 1, 14);
      c = round_mul(c, 1, 14);
      sn = sneg ? -s : s;
      cs = cneg ? -c : c;
    endfunction

    function void note_command(glct_pkg::glct_in_t cmd);
      glct_pkg::glct_out_t res;
      int idx;
      longint pe, pn, ce, cn, ge, gn, sn, cs, sp, sc, fwd, xe, xn, off;
      longint unsigned rem, den, q, moff;
      res = '0;
      idx = cmd.gate_index;
      pe = cmd.first_east;
      pn = cmd.first_north;
      ce = cmd.second_east;
      cn = cmd.second_north;
      if (idx >= GATES) begin
        res.status = glct_pkg::ST_RANGE;
      end else if (cmd.kind == glct_pkg::KIND_SET) begin
        gate_east[idx] = pe;
        gate_north[idx] = pn;
        gate_heading[idx] = cmd.heading;
        gate_valid[idx] = 1;
        if (idx == 0)
          for (int i = 1; i < GATES; i++) gate_valid[i] = 0;
      end else if (cmd.kind == glct_pkg::KIND_CLEAR) begin
        gate_valid[idx] = 0;
      end else if (!gate_valid[idx]) begin
        res.status = glct_pkg::ST_INVALID;
      end else if (cmd.kind == glct_pkg::KIND_GET) begin
        res.gate_east_out = 32'(gate_east[idx]);
        res.gate_north_out = 32'(gate_north[idx]);
        res.gate_heading_out = 32'(gate_heading[idx]);
      end else begin
        ge = gate_east[idx];
        gn = gate_north[idx];
        sin_cos(gate_heading[idx], sn, cs);
        sp = (pe - ge) * cs + (pn - gn) * sn;
        sc = (ce - ge) * cs + (cn - gn) * sn;
        fwd = sc - sp;
        if (fwd > 0 && sp <= 0 && sc > 0) begin
          rem = -sp;
          den = fwd;
          q = 0;
          for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
              rem -= den;
              q |= 1;
            end
          end
          if (q > 65536) q = 65536;
          xe = (pe - ge) + round_mul(longint'(q), ce - pe, 16);
          xn = (pn - gn) + round_mul(longint'(q), cn - pn, 16);
          off = -xe * sn + xn * cs;
          moff = (off < 0) ? longint'(-off) : off;
          if (moff <= (half_width << 16)) begin
            res.crossed = 1;
            res.fraction = q[16:0];
          end
        end
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(glct_pkg::glct_out_t got);
      glct_pkg::glct_out_t exp_r;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.crossed !== exp_r.crossed) begin
        $error("crossed: expected %0d, actual %0d", exp_r.crossed, got.crossed);
        errors++;
      end
      if (got.fraction !== exp_r.fraction) begin
        $error("fraction: expected %0d, actual %0d", exp_r.fraction, got.fraction);
        errors++;
      end
      if (got.gate_east_out !== exp_r.gate_east_out) begin
        $error("gate_east_out: expected %0d, actual %0d", exp_r.gate_east_out,
               got.gate_east_out);
        errors++;
      end
      if (got.gate_north_out !== exp_r.gate_north_out) begin
        $error("gate_north_out: expected %0d, actual %0d", exp_r.gate_north_out,
               got.gate_north_out);
        errors++;
      end
      if (got.gate_heading_out !== exp_r.gate_heading_out) begin
        $error("gate_heading_out: expected %0d, actual %0d", exp_r.gate_heading_out,
               got.gate_heading_out);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  glct_pkg::glct_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  glct_pkg::glct_out_t out_data;
  logic                cfg_we;
  logic [23:0]         cfg_wdata;

  crossing_scoreboard sb;
  bit idle_on;
  bit hold_request;
  int set_east[GATES];
  int set_north[GATES];

  gate_line_crossing_table_unit #(.GATE_COUNT(GATES)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic glct_pkg::glct_in_t make_cmd(logic [1:0] kind, int idx, int fe, int fn,
                                                  int se, int sn, int hd);
    glct_pkg::glct_in_t c;
    c.kind = kind;
    c.gate_index = 8'(idx);
    c.first_east = fe;
    c.first_north = fn;
    c.second_east = se;
    c.second_north = sn;
    c.heading = hd;
    return c;
  endfunction

  function automatic int near(int base, int span);
    return base + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic glct_pkg::glct_in_t random_cmd();
    glct_pkg::glct_in_t c;
    int pick, idx, pe, pn;
    c.kind = 2'($urandom);
    c.gate_index = 8'($urandom);
    c.first_east = $urandom;
    c.first_north = $urandom;
    c.second_east = $urandom;
    c.second_north = $urandom;
    c.heading = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 6) return c;
    idx = ($urandom_range(0, 19) == 0) ? $urandom_range(GATES, 255)
        : ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, GATES - 1);
    c.gate_index = 8'(idx);
    if (pick < 22) begin
      c.kind = glct_pkg::KIND_SET;
      if ($urandom_range(0, 3) != 0) begin
        c.first_east = near(0, 1 << 20);
        c.first_north = near(0, 1 << 20);
      end
      if (idx < GATES) begin
        set_east[idx] = c.first_east;
        set_north[idx] = c.first_north;
      end
    end else if (pick < 28) begin
      c.kind = glct_pkg::KIND_CLEAR;
    end else if (pick < 38) begin
      c.kind = glct_pkg::KIND_GET;
    end else begin
      c.kind = glct_pkg::KIND_CHECK;
      if (idx < GATES && $urandom_range(0, 9) != 0) begin
        pe = near(set_east[idx], 4096);
        pn = near(set_north[idx], 4096);
        c.first_east = pe;
        c.first_north = pn;
        c.second_east = near(pe, 3072);
        c.second_north = near(pn, 3072);
      end
    end
    return c;
  endfunction

  task automatic send_cmd(glct_pkg::glct_in_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_command(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_half_width(logic [23:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.half_width = v;
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (hold_request) begin
        hold_request = 0;
        stall = 400;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [23:0] widths[5];
    sb = new();
    foreach (set_east[i]) begin
      set_east[i] = 0;
      set_north[i] = 0;
    end
    idle_on = 0;
    hold_request = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(make_cmd(glct_pkg::KIND_GET, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_GET, 0, -1, -1, -1, -1, -1));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 0, -256, 0, 256, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 0, 0, 0, 256, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 0, 256, 0, -256, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 0, -256, 3000, 256, 3000, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 0, -256, 100, -256, 900, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 205887));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 2, 0, 0, 0, 0, -205887));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 3, 0, 0, 0, 0, 32'h8000_0000));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 4, 0, 0, 0, 0, 32'h7fff_ffff));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 5, 0, 0, 0, 0, 102944));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 6, 0, 0, 0, 0, -102945));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 5, 0, -300, 0, 300, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 6, 0, 300, 0, -300, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 3, 300, 0, -300, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_GET, 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CLEAR, 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_GET, 1, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_GET, 2, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_SET, 8, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(glct_pkg::KIND_CHECK, 255, 0, 0, 0, 0, 0));

    widths = '{24'd0, 24'hff_ffff, 24'd1, 24'($urandom_range(0, 24'hff_ffff)), 24'd2560};
    foreach (widths[p]) begin
      write_half_width(widths[p]);
      if (p == 1) hold_request = 1;
      for (int n = 0; n < 136; n++) begin
        if (n % 34 == 0) idle_on = $urandom_range(0, 2) != 0;
        send_cmd(random_cmd());
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
rtl/glct_pkg.sv
rtl/glct_ram.sv
rtl/glct_mul.sv
rtl/gate_line_crossing_table_unit.sv
bench/tb_gate_line_crossing_table_unit.sv
